@@ rtl/sbra_pkg.sv @@
package sbra_pkg;

  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned START_W   = 8;
  localparam int unsigned SEG_W     = 32;
  localparam int unsigned SEG_IDX_W = $clog2(SEG_W);
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned DOT_SLOTS = 2;

  localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(64);

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_QUERY = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_APPLY  = 4'b0100,
    S_HOLD   = 4'b1000
  } state_e;

  typedef struct packed {
    logic             clear;
    logic             step;
    logic [LEN_W-1:0] want;
  } scan_ctl_t;

endpackage

@@ rtl/sbra_cell.sv @@
module sbra_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       shift_i,
  input  logic [sbra_pkg::SEG_W-1:0] seg_i,
  output logic [sbra_pkg::SEG_W-1:0] seg_o
);

  logic [sbra_pkg::SEG_W-1:0] seg_q;
  logic [sbra_pkg::SEG_W-1:0] seg_d;

  assign seg_d = shift_i ? seg_i : seg_q;
  assign seg_o = seg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= '0;
    end else begin
      seg_q <= seg_d;
    end
  end

endmodule

@@ rtl/sbra_scan.sv @@
module sbra_scan #(
  parameter int unsigned GW = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sbra_pkg::scan_ctl_t        ctl_i,
  input  logic [sbra_pkg::SEG_W-1:0] free_i,
  input  logic [GW-1:0]              base_i,
  output logic                       found_o,
  output logic [GW-1:0]              start_o
);

  localparam int unsigned SW  = sbra_pkg::SEG_W;
  localparam int unsigned LW  = sbra_pkg::LEN_W;
  localparam int unsigned SIW = sbra_pkg::SEG_IDX_W;

  logic [LW-1:0]  carry_len_q, carry_len_d;
  logic [GW-1:0]  carry_start_q, carry_start_d;
  logic           found_q, found_d;
  logic [GW-1:0]  start_q, start_d;

  logic           any_used [SW];
  logic [SIW-1:0] last_used [SW];
  logic [LW-1:0]  len_a [SW];
  logic [GW-1:0]  st_a [SW];
  logic [SW-1:0]  hit;
  logic [GW-1:0]  sel_start;

  always_comb begin
    for (int j = 0; j < SW; j++) begin
      any_used[j]  = 1'b0;
      last_used[j] = '0;
      for (int i = 0; i < SW; i++) begin
        if (i <= j && !free_i[i]) begin
          any_used[j]  = 1'b1;
          last_used[j] = SIW'(i);
        end
      end
      if (any_used[j]) begin
        len_a[j] = LW'(j) - LW'(last_used[j]);
        st_a[j]  = base_i + GW'(last_used[j]) + GW'(1);
      end else begin
        len_a[j] = carry_len_q + LW'(j) + LW'(1);
        st_a[j]  = (carry_len_q == '0) ? base_i : carry_start_q;
      end
      hit[j] = (len_a[j] >= ctl_i.want);
    end
    sel_start = '0;
    for (int j = SW - 1; j >= 0; j--) begin
      if (hit[j]) begin
        sel_start = st_a[j];
      end
    end
  end

  always_comb begin
    carry_len_d   = carry_len_q;
    carry_start_d = carry_start_q;
    found_d       = found_q;
    start_d       = start_q;
    if (ctl_i.clear) begin
      carry_len_d = '0;
      found_d     = 1'b0;
    end else if (ctl_i.step && !found_q) begin
      if (|hit) begin
        found_d = 1'b1;
        start_d = sel_start;
      end else begin
        carry_len_d   = (len_a[SW-1] > sbra_pkg::LEN_SAT) ? sbra_pkg::LEN_SAT : len_a[SW-1];
        carry_start_d = st_a[SW-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_len_q <= '0;
      found_q     <= 1'b0;
    end else begin
      carry_len_q <= carry_len_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_start_q <= carry_start_d;
    start_q       <= start_d;
  end

  assign found_o = found_q;
  assign start_o = start_q;

endmodule

@@ rtl/slot_bitmap_run_allocator_unit.sv @@
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tdata: slot_count[5:0], start_slot[13:6]; tuser: opcode[1:0]
// m_axis    out  tdata: run_start, dir_empty above it; tuser: no_room
//
// The bitmap sits in a ring of 32-slot cells that rotates one segment per cycle
// during the search and mark passes. An allocate runs a search rotation, a mark
// rotation and a hand-off step that waits for room on m_axis; the result is
// registered onto m_axis as the hand-off ends. Other requests skip the search.
// Reset clears the bitmap at once. A new word is taken while a result
// waits on m_axis; a finished result waits while m_axis stalls.
module slot_bitmap_run_allocator_unit #(
  parameter int unsigned NUM_SLOTS = 256,
  localparam int unsigned IDXW     = $clog2(NUM_SLOTS + 1),
  localparam int unsigned OUT_W    = ((IDXW + 1 + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,  // slot_count, start_slot
  input  logic [1:0]       s_axis_tuser,  // opcode
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,  // run_start, dir_empty
  output logic [0:0]       m_axis_tuser   // no_room
);

  localparam int unsigned SW        = sbra_pkg::SEG_W;
  localparam int unsigned SIW       = sbra_pkg::SEG_IDX_W;
  localparam int unsigned NUM_CELLS = (NUM_SLOTS + SW - 1) / SW;
  localparam int unsigned CELLW     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int unsigned GW        = $clog2(NUM_CELLS * SW + 256 + 64);
  localparam int unsigned CW        = sbra_pkg::COUNT_W;

  sbra_pkg::state_e        state_q, state_d;
  logic [CELLW-1:0]        seg_idx_q, seg_idx_d;
  sbra_pkg::opcode_e       op_q;
  logic [CW-1:0]           count_q;
  logic [sbra_pkg::START_W-1:0] first_q;
  logic                    used_acc_q, used_acc_d;
  logic [IDXW-1:0]         res_start_q;
  logic                    res_noroom_q;
  logic                    res_empty_q;
  logic                    out_valid_q, out_valid_d;
  logic [IDXW-1:0]         out_start_q;
  logic                    out_noroom_q;
  logic                    out_empty_q;

  logic                    in_fire;
  logic                    shift;
  logic                    last_seg;
  logic                    out_free;
  logic [SW-1:0]           cell_seg [NUM_CELLS];
  logic [SW-1:0]           head_new;
  logic [SW-1:0]           valid_mask;
  logic [SW-1:0]           run_mask;
  logic [SW-1:0]           applied;
  logic                    used_now;
  logic [GW-1:0]           base;
  logic [GW-1:0]           lo, hi;
  logic                    do_set, do_clr;
  logic [GW-1:0]           g;
  sbra_pkg::scan_ctl_t     scan_ctl;
  logic                    scan_found;
  logic [GW-1:0]           scan_start;

  assign s_axis_tready = (state_q == sbra_pkg::S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign shift         = (state_q == sbra_pkg::S_SEARCH) || (state_q == sbra_pkg::S_APPLY);
  assign last_seg      = (seg_idx_q == CELLW'(NUM_CELLS - 1));
  assign out_free      = !out_valid_q || m_axis_tready;
  assign base          = GW'({seg_idx_q, SIW'(0)});

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    if (i == NUM_CELLS - 1) begin : g_tail
      sbra_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .seg_i   (head_new),
        .seg_o   (cell_seg[i])
      );
    end else begin : g_body
      sbra_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .seg_i   (cell_seg[i+1]),
        .seg_o   (cell_seg[i])
      );
    end
  end

  always_comb begin
    lo     = '0;
    hi     = '0;
    do_set = 1'b0;
    do_clr = 1'b0;
    case (op_q)
      sbra_pkg::OP_ALLOC: begin
        lo     = scan_start;
        hi     = scan_start + GW'(count_q);
        do_set = scan_found;
      end
      sbra_pkg::OP_FREE: begin
        lo     = GW'(first_q);
        hi     = GW'(first_q) + GW'(count_q);
        do_clr = 1'b1;
      end
      sbra_pkg::OP_INIT: begin
        lo     = '0;
        hi     = GW'(sbra_pkg::DOT_SLOTS);
        do_set = 1'b1;
      end
      default: begin
        lo = '0;
        hi = '0;
      end
    endcase
  end

  always_comb begin
    used_now = 1'b0;
    g        = '0;
    for (int j = 0; j < SW; j++) begin
      g             = base + GW'(j);
      valid_mask[j] = (g < GW'(NUM_SLOTS));
      run_mask[j]   = (g >= lo) && (g < hi) && valid_mask[j];
      if (do_set) begin
        applied[j] = cell_seg[0][j] | run_mask[j];
      end else if (do_clr) begin
        applied[j] = cell_seg[0][j] & ~run_mask[j];
      end else begin
        applied[j] = cell_seg[0][j];
      end
      if (applied[j] && g >= GW'(sbra_pkg::DOT_SLOTS)) begin
        used_now = 1'b1;
      end
    end
    head_new = (state_q == sbra_pkg::S_APPLY) ? applied : cell_seg[0];
  end

  assign scan_ctl.clear = in_fire;
  assign scan_ctl.step  = (state_q == sbra_pkg::S_SEARCH);
  assign scan_ctl.want  = (count_q == '0) ? sbra_pkg::LEN_W'(1) : sbra_pkg::LEN_W'(count_q);

  sbra_scan #(
    .GW (GW)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .free_i  (~cell_seg[0] & valid_mask),
    .base_i  (base),
    .found_o (scan_found),
    .start_o (scan_start)
  );

  always_comb begin
    state_d     = state_q;
    seg_idx_d   = seg_idx_q;
    used_acc_d  = used_acc_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    unique case (state_q)
      sbra_pkg::S_IDLE: begin
        if (in_fire) begin
          used_acc_d = 1'b0;
          seg_idx_d  = '0;
          state_d    = (sbra_pkg::opcode_e'(s_axis_tuser) == sbra_pkg::OP_ALLOC) ?
                       sbra_pkg::S_SEARCH : sbra_pkg::S_APPLY;
        end
      end
      sbra_pkg::S_SEARCH: begin
        seg_idx_d = last_seg ? '0 : seg_idx_q + CELLW'(1);
        if (last_seg) begin
          state_d = sbra_pkg::S_APPLY;
        end
      end
      sbra_pkg::S_APPLY: begin
        seg_idx_d  = last_seg ? '0 : seg_idx_q + CELLW'(1);
        used_acc_d = used_acc_q | used_now;
        if (last_seg) begin
          state_d = sbra_pkg::S_HOLD;
        end
      end
      sbra_pkg::S_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = sbra_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sbra_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbra_pkg::S_IDLE;
      seg_idx_q   <= '0;
      used_acc_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seg_idx_q   <= seg_idx_d;
      used_acc_q  <= used_acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= sbra_pkg::opcode_e'(s_axis_tuser);
      count_q <= s_axis_tdata[CW-1:0];
      first_q <= s_axis_tdata[CW+sbra_pkg::START_W-1:CW];
    end
    if (state_q == sbra_pkg::S_APPLY && last_seg) begin
      res_empty_q <= !(used_acc_q | used_now);
      if (op_q == sbra_pkg::OP_ALLOC) begin
        res_noroom_q <= !scan_found;
        res_start_q  <= scan_found ? IDXW'(scan_start) : IDXW'(NUM_SLOTS);
      end else begin
        res_noroom_q <= 1'b0;
        res_start_q  <= '0;
      end
    end
    if (state_q == sbra_pkg::S_HOLD && out_free) begin
      out_start_q  <= res_start_q;
      out_noroom_q <= res_noroom_q;
      out_empty_q  <= res_empty_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_empty_q, out_start_q});
  assign m_axis_tuser  = out_noroom_q;

  a_idle_home : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbra_pkg::S_IDLE) |-> (seg_idx_q == '0))
    else $error("cell ring not at home position while idle");

  a_pass_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbra_pkg::S_APPLY && $past(state_q) == sbra_pkg::S_SEARCH)
      |-> (seg_idx_q == '0))
    else $error("apply pass started off the first segment");

  a_found_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbra_pkg::S_APPLY && op_q == sbra_pkg::OP_ALLOC && scan_found)
      |-> (scan_start < GW'(NUM_SLOTS)))
    else $error("allocated run starts beyond the bitmap");

  a_noroom_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_noroom_q) |-> (out_start_q == IDXW'(NUM_SLOTS)))
    else $error("no-room word carries a wrong run start");

  a_hold_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbra_pkg::S_HOLD && !out_free) |=> (state_q == sbra_pkg::S_HOLD))
    else $error("finished result dropped while output stalled");

endmodule
